// File: rtl/core/pus_pkg.sv
// pus_pkg: shared types and constants of the periodic user scheduler.
// No dependencies. Used by pus_key_unit and periodic_user_scheduler.
package pus_pkg;

    localparam int FUNC_W = 2;
    localparam int ID_W   = 16;
    localparam int PER_W  = 16;
    localparam int STAT_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_NEXT  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_ADDED   = 3'd0,
        STAT_SERVED  = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_EMPTY   = 3'd3,
        STAT_CLEARED = 3'd4
    } status_t;

endpackage

// File: rtl/core/pus_key_unit.sv
// pus_key_unit: shared heap key comparator and saturating due-time adder.
// Key layout is {due, id, period}, so one unsigned compare gives serving order.
// Depends on pus_pkg.
module pus_key_unit #(
    parameter int TIME_WIDTH = 40
) (
    input  logic [TIME_WIDTH+pus_pkg::ID_W+pus_pkg::PER_W-1:0] cmp_a,
    input  logic [TIME_WIDTH+pus_pkg::ID_W+pus_pkg::PER_W-1:0] cmp_b,
    input  logic [TIME_WIDTH-1:0]                             add_due,
    input  logic [pus_pkg::PER_W-1:0]                         add_per,
    output logic                                              a_lt_b,
    output logic [TIME_WIDTH-1:0]                             due_sum
);
    import pus_pkg::*;

    logic [TIME_WIDTH:0] sum_full;

    assign a_lt_b   = cmp_a < cmp_b;
    assign sum_full = {1'b0, add_due} + (TIME_WIDTH+1)'(add_per);
    // saturate on carry out of the time range
    assign due_sum  = sum_full[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum_full[TIME_WIDTH-1:0];

endmodule

// File: rtl/core/periodic_user_scheduler.sv
// periodic_user_scheduler: min-heap periodic scheduler with a sequenced sift engine.
// Holds the heap memory and the sequencer; uses pus_key_unit and pus_pkg.
//
//  channel | direction | ports
//  --------+-----------+------------------------------------------------
//  s_      | in        | s_valid s_ready s_func s_user_id s_user_period
//  m_      | out       | m_valid m_ready m_served_id m_status
//
// Add: from the new leaf, per level read the parent and move it down while the key
// is below it; write the key where the walk stops, at the latest at the root.
// Next: read the root, add its period to its due time, then per level read the
// children, pick the smaller and move it up while it is below the key.
// Clear, full and empty items go straight to the done state.
// s_ready is high only while the sequencer is idle; a result stalls it in ST_DONE
// until the output register is free. Reset clears state, count and m_valid only.
module periodic_user_scheduler #(
    parameter int CAPACITY   = 64,
    parameter int TIME_WIDTH = 40
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [pus_pkg::FUNC_W-1:0]   s_func,
    input  logic [pus_pkg::ID_W-1:0]     s_user_id,
    input  logic [pus_pkg::PER_W-1:0]    s_user_period,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pus_pkg::ID_W-1:0]     m_served_id,
    output logic [pus_pkg::STAT_W-1:0]   m_status
);
    import pus_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 1;
    localparam int KW = TIME_WIDTH + ID_W + PER_W;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_UP_RD  = 9'b000000010,
        ST_UP_CMP = 9'b000000100,
        ST_RT_RD  = 9'b000001000,
        ST_RT_ADD = 9'b000010000,
        ST_DN_RD  = 9'b000100000,
        ST_DN_SEL = 9'b001000000,
        ST_DN_CMP = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [KW-1:0]     key_reg, key_next;
    logic [KW-1:0]     child_reg, child_next;
    logic [AW-1:0]     cidx_reg, cidx_next;
    logic              rvalid_reg, rvalid_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    status_t           res_status_reg, res_status_next;
    logic              m_valid_reg, m_valid_next;
    logic [ID_W-1:0]   m_id_reg, m_id_next;
    status_t           m_status_reg, m_status_next;

    logic [KW-1:0]     heap_mem [CAPACITY];
    logic [KW-1:0]     rd_a_reg, rd_b_reg;
    logic [AW-1:0]     rd_addr_a, rd_addr_b;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [KW-1:0]     wr_data;

    logic [KW-1:0]         cmp_a, cmp_b;
    logic                  a_lt_b;
    logic [TIME_WIDTH-1:0] due_sum;

    logic [AW-1:0]     parent_idx;
    logic [LW-1:0]     left_idx, right_idx;
    logic              accept;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_served_id = m_id_reg;
    assign m_status   = m_status_reg;

    assign parent_idx = AW'((pos_reg - AW'(1)) >> 1);
    assign left_idx   = {pos_reg, 1'b1};
    assign right_idx  = LW'(left_idx + LW'(1));

    pus_key_unit #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_key_unit (
        .cmp_a   (cmp_a),
        .cmp_b   (cmp_b),
        .add_due (rd_a_reg[KW-1 -: TIME_WIDTH]),
        .add_per (rd_a_reg[PER_W-1:0]),
        .a_lt_b  (a_lt_b),
        .due_sum (due_sum)
    );

    always_comb begin
        case (state_reg)
            ST_UP_CMP: begin
                cmp_a = key_reg;
                cmp_b = rd_a_reg;
            end
            ST_DN_SEL: begin
                cmp_a = rd_b_reg;
                cmp_b = rd_a_reg;
            end
            default: begin
                cmp_a = child_reg;
                cmp_b = key_reg;
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        child_next      = child_reg;
        cidx_next       = cidx_reg;
        rvalid_next     = rvalid_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_id_next       = m_id_reg;
        m_status_next   = m_status_reg;
        rd_addr_a       = '0;
        rd_addr_b       = '0;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = key_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_id_next = '0;
                    case (func_t'(s_func))
                        FUNC_ADD: begin
                            if (count_reg == CW'(CAPACITY)) begin
                                res_status_next = STAT_FULL;
                                state_next      = ST_DONE;
                            end else begin
                                key_next   = {TIME_WIDTH'(s_user_period), s_user_id,
                                              s_user_period};
                                pos_next   = count_reg[AW-1:0];
                                count_next = CW'(count_reg + CW'(1));
                                res_status_next = STAT_ADDED;
                                state_next = ST_UP_RD;
                            end
                        end
                        FUNC_NEXT: begin
                            if (count_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                                state_next      = ST_DONE;
                            end else begin
                                res_status_next = STAT_SERVED;
                                state_next      = ST_RT_RD;
                            end
                        end
                        default: begin
                            count_next      = '0;
                            res_status_next = STAT_CLEARED;
                            state_next      = ST_DONE;
                        end
                    endcase
                end
            end
            ST_UP_RD: begin
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    rd_addr_a  = parent_idx;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                wr_en = 1'b1;
                if (a_lt_b) begin
                    wr_data    = rd_a_reg;
                    pos_next   = parent_idx;
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_RT_RD: begin
                rd_addr_a  = '0;
                state_next = ST_RT_ADD;
            end
            ST_RT_ADD: begin
                key_next    = {due_sum, rd_a_reg[KW-TIME_WIDTH-1:0]};
                res_id_next = rd_a_reg[PER_W +: ID_W];
                pos_next    = '0;
                state_next  = ST_DN_RD;
            end
            ST_DN_RD: begin
                if (left_idx >= LW'(count_reg)) begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    rvalid_next = right_idx < LW'(count_reg);
                    rd_addr_a   = left_idx[AW-1:0];
                    rd_addr_b   = (right_idx < LW'(count_reg)) ? right_idx[AW-1:0]
                                                               : left_idx[AW-1:0];
                    state_next  = ST_DN_SEL;
                end
            end
            ST_DN_SEL: begin
                if (rvalid_reg && a_lt_b) begin
                    child_next = rd_b_reg;
                    cidx_next  = right_idx[AW-1:0];
                end else begin
                    child_next = rd_a_reg;
                    cidx_next  = left_idx[AW-1:0];
                end
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                wr_en = 1'b1;
                if (a_lt_b) begin
                    wr_data    = child_reg;
                    pos_next   = cidx_reg;
                    state_next = ST_DN_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_id_next     = res_id_reg;
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        key_reg        <= key_next;
        child_reg      <= child_next;
        cidx_reg       <= cidx_next;
        rvalid_reg     <= rvalid_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        m_id_reg       <= m_id_next;
        m_status_reg   <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= heap_mem[rd_addr_a];
        rd_b_reg <= heap_mem[rd_addr_b];
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_func != FUNC_ADD && s_func != FUNC_NEXT) |=> count_reg == '0)
        else $error("clear item left entries");

    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_func == FUNC_ADD && count_reg == CW'(CAPACITY))
        |=> count_reg == CW'(CAPACITY))
        else $error("dropped add changed count");

    a_sift_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UP_CMP || state_reg == ST_DN_CMP || state_reg == ST_DN_RD)
        |-> CW'(pos_reg) < count_reg)
        else $error("sift position outside live heap");

    a_done_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("finished item not presented");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for periodic_user_scheduler (min-heap periodic scheduler).
// Needs pus_pkg and the scheduler RTL; predicts each result from its own copy of the store.
module tb;
    import pus_pkg::*;

    localparam int          CAP         = 64;
    localparam int          TW          = 40;
    localparam logic [TW-1:0] DUE_MAX   = {TW{1'b1}};
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          HOLD_AT     = 200;
    localparam int          HOLD_LEN    = 500;
    localparam int          MAX_SHOWN   = 10;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   uid;
        logic [PER_W-1:0]  per;
        int                gap;
        bit                drain;
    } sched_req_t;

    typedef struct {
        logic [ID_W-1:0] sid;
        status_t         st;
    } sched_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [FUNC_W-1:0] s_func = '0;
    logic [ID_W-1:0] s_user_id = '0;
    logic [PER_W-1:0] s_user_period = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [ID_W-1:0] m_served_id;
    logic [STAT_W-1:0] m_status;

    sched_req_t pending[$];
    sched_req_t cur_req;
    sched_res_t due_results[$];

    logic [ID_W-1:0]  sch_id[CAP];
    logic [PER_W-1:0] sch_per[CAP];
    logic [TW-1:0]    sch_due[CAP];
    int               sch_count = 0;

    int n_sent = 0;
    int n_recv = 0;
    int mismatches = 0;
    int tx_wait = 0;
    bit tx_loaded = 1'b0;
    int rx_wait = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;
    int cycles = 0;

    periodic_user_scheduler #(.CAPACITY(CAP), .TIME_WIDTH(TW)) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_user_id    (s_user_id),
        .s_user_period(s_user_period),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_served_id  (m_served_id),
        .m_status     (m_status)
    );

    always #10 aclk = ~aclk;

    function automatic sched_res_t serve_model(sched_req_t rq);
        sched_res_t r;
        int best;
        logic [TW-1:0] d;
        logic [TW-1:0] p;
        r.sid = '0;
        r.st = STAT_CLEARED;
        case (rq.func)
            FUNC_ADD: begin
                if (sch_count >= CAP) begin
                    r.st = STAT_FULL;
                end else begin
                    sch_id[sch_count] = rq.uid;
                    sch_per[sch_count] = rq.per;
                    sch_due[sch_count] = TW'(rq.per);
                    sch_count++;
                    r.st = STAT_ADDED;
                end
            end
            FUNC_NEXT: begin
                if (sch_count == 0) begin
                    r.st = STAT_EMPTY;
                end else begin
                    best = 0;
                    for (int i = 1; i < sch_count; i++) begin
                        if (sch_due[i] != sch_due[best]) begin
                            if (sch_due[i] < sch_due[best]) best = i;
                        end else if (sch_id[i] != sch_id[best]) begin
                            if (sch_id[i] < sch_id[best]) best = i;
                        end else if (sch_per[i] < sch_per[best]) begin
                            best = i;
                        end
                    end
                    r.sid = sch_id[best];
                    d = sch_due[best];
                    p = TW'(sch_per[best]);
                    if (d >= DUE_MAX || p > DUE_MAX - d) sch_due[best] = DUE_MAX;
                    else sch_due[best] = d + p;
                    r.st = STAT_SERVED;
                end
            end
            default: begin
                sch_count = 0;
                r.st = STAT_CLEARED;
            end
        endcase
        return r;
    endfunction

    task automatic push_req(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                            logic [PER_W-1:0] per, int gap, bit drain);
        sched_req_t rq;
        rq.func = f;
        rq.uid = id;
        rq.per = per;
        rq.gap = gap;
        rq.drain = drain;
        pending.push_back(rq);
    endtask

    function automatic logic [PER_W-1:0] pick_period();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5) return PER_W'($urandom_range(0, 8));
        if (k == 5) return '1;
        if (k == 6) return PER_W'(1);
        return PER_W'($urandom);
    endfunction

    // driver
    always @(posedge aclk) begin
        logic offer;
        int sent_now;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            offer = s_valid;
            sent_now = n_sent;
            if (s_valid && s_ready) begin
                due_results.push_back(serve_model(cur_req));
                sent_now = n_sent + 1;
                n_sent <= sent_now;
                offer = 1'b0;
            end
            if (!offer && pending.size() > 0) begin
                if (!tx_loaded) begin
                    tx_wait = pending[0].gap;
                    tx_loaded = 1'b1;
                end
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (!pending[0].drain || sent_now == n_recv) begin
                    cur_req = pending.pop_front();
                    tx_loaded = 1'b0;
                    s_func <= cur_req.func;
                    s_user_id <= cur_req.uid;
                    s_user_period <= cur_req.per;
                    offer = 1'b1;
                end
            end
            s_valid <= offer;
        end
    end

    // long receiver hold-off, once
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cnt <= 0;
        end else if (!hold_done && n_recv >= HOLD_AT) begin
            hold_cnt <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        logic rdy;
        sched_res_t exp_r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rdy = m_ready;
            if (m_valid && m_ready) begin
                n_recv <= n_recv + 1;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected item: served_id=%0d status=%0d",
                                 m_served_id, m_status);
                end else begin
                    exp_r = due_results.pop_front();
                    if (m_served_id !== exp_r.sid || m_status !== exp_r.st) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("item %0d: expected id=%0d status=%0d, got id=%0d status=%0d",
                                     n_recv, exp_r.sid, exp_r.st, m_served_id, m_status);
                    end
                end
                rdy = 1'b0;
                rx_wait = (n_recv % 256 < 40) ? 0 : $urandom_range(0, 8);
            end
            if (!rdy && hold_cnt == 0) begin
                if (rx_wait > 0) rx_wait--;
                else rdy = 1'b1;
            end
            m_ready <= rdy;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int n_add;
        int n_next;
        int gmax;
        int g;
        bit drain_first;

        // directed
        push_req(FUNC_NEXT, '1, '1, 0, 1'b0);
        push_req(FUNC_ADD, 16'hFFFF, 16'hFFFF, 0, 1'b0);
        push_req(FUNC_ADD, 16'h0000, 16'h0001, 1, 1'b0);
        push_req(FUNC_ADD, 16'h0005, 16'h0000, 0, 1'b0);
        push_req(FUNC_NEXT, 16'h0000, 16'h0000, 0, 1'b0);
        push_req(FUNC_NEXT, 16'hFFFF, 16'hFFFF, 2, 1'b0);
        push_req(FUNC_NEXT, 16'h0000, 16'h0000, 0, 1'b0);
        push_req(FUNC_SPARE, 16'hFFFF, 16'hFFFF, 0, 1'b0);
        push_req(FUNC_NEXT, 16'h1234, 16'h0000, 0, 1'b0);
        push_req(FUNC_ADD, 16'd7, 16'd3, 0, 1'b0);
        push_req(FUNC_ADD, 16'd7, 16'd2, 0, 1'b0);
        push_req(FUNC_ADD, 16'd7, 16'd3, 0, 1'b0);
        push_req(FUNC_ADD, 16'd6, 16'd6, 0, 1'b0);
        for (int i = 0; i < 6; i++) push_req(FUNC_NEXT, '0, '0, i % 3, 1'b0);
        push_req(FUNC_CLEAR, 16'hFFFF, 16'h0000, 0, 1'b1);
        push_req(FUNC_ADD, 16'h0000, 16'hFFFF, 0, 1'b0);
        push_req(FUNC_ADD, 16'hFFFF, 16'h0001, 0, 1'b0);
        push_req(FUNC_NEXT, '0, '0, 0, 1'b0);
        push_req(FUNC_NEXT, '0, '0, 0, 1'b0);
        push_req(FUNC_NEXT, '0, '0, 0, 1'b0);

        // random: mostly clear / fill / serve cases, some noise
        while (pending.size() < 975) begin
            gmax = ($urandom_range(0, 4) == 0) ? 0 : 8;
            drain_first = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 4) != 0) begin
                push_req($urandom_range(0, 1) ? FUNC_CLEAR : FUNC_SPARE,
                         ID_W'($urandom), PER_W'($urandom), $urandom_range(0, gmax),
                         drain_first);
                n_add = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 70)
                                                   : $urandom_range(1, 12);
                for (int i = 0; i < n_add; i++) begin
                    g = $urandom_range(0, gmax);
                    if ($urandom_range(0, 2) == 0)
                        push_req(FUNC_ADD, ID_W'($urandom), pick_period(), g, 1'b0);
                    else
                        push_req(FUNC_ADD, ID_W'($urandom_range(0, 15)), pick_period(),
                                 g, 1'b0);
                end
                n_next = $urandom_range(1, 30);
                for (int i = 0; i < n_next; i++) begin
                    g = $urandom_range(0, gmax);
                    if ($urandom_range(0, 7) == 0)
                        push_req(FUNC_ADD, ID_W'($urandom_range(0, 15)), pick_period(),
                                 g, 1'b0);
                    else
                        push_req(FUNC_NEXT, ID_W'($urandom), PER_W'($urandom), g, 1'b0);
                end
            end else begin
                n_next = $urandom_range(1, 10);
                for (int i = 0; i < n_next; i++)
                    push_req(FUNC_W'($urandom_range(0, 3)), ID_W'($urandom),
                             PER_W'($urandom), $urandom_range(0, gmax),
                             drain_first && i == 0);
            end
        end

        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_valid) @(posedge aclk);
        while (n_recv != n_sent) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (due_results.size() != 0) mismatches += due_results.size();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
